### rtl/core/utf8_stream_decoder_macros.svh
// Assertion macros for the UTF-8 stream decoder.
// Used by utf8_stream_decoder.sv; no other dependencies.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, off during reset.
`define U8SD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, off during reset.
`define U8SD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define U8SD_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define U8SD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### rtl/core/u8sd_pkg.sv
// Shared types and byte-range constants for the UTF-8 stream decoder.
// No dependencies.
`default_nettype none

package u8sd_pkg;

  localparam int unsigned CpW = 21;

  // Byte range boundaries
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] CONT_MIN  = 8'h80;
  localparam logic [7:0] CONT_MAX  = 8'hBF;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MAX = 8'hF7;

  // Continuation bytes owed after each lead kind
  localparam logic [1:0] OWED_NONE = 2'd0;
  localparam logic [1:0] OWED_ONE  = 2'd1;
  localparam logic [1:0] OWED_TWO  = 2'd2;
  localparam logic [1:0] OWED_THR  = 2'd3;

  typedef struct packed {
    logic [1:0]     owed;
    logic [CpW-1:0] acc;
  } dec_state_t;

  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] code_point;
    logic           invalid;
    logic           text_done;
  } dec_result_t;

endpackage

`default_nettype wire

### rtl/core/u8sd_step.sv
// One-byte decode step: next sequence state and optional result.
// Depends on u8sd_pkg.
`default_nettype none

module u8sd_step import u8sd_pkg::*; #(
  parameter int HELD_W = 8
) (
  input  logic [7:0]        byte_value,
  input  logic [HELD_W-1:0] char_class,
  input  logic              end_of_text,
  input  dec_state_t        state,
  input  logic [HELD_W-1:0] held_class,
  output dec_state_t        state_next,
  output logic [HELD_W-1:0] held_class_next,
  output dec_result_t       result
);

  logic           is_cont;
  logic [1:0]     owed_dec;
  logic [CpW-1:0] acc_shift;

  assign is_cont   = (byte_value >= CONT_MIN) && (byte_value <= CONT_MAX);
  assign owed_dec  = state.owed - 2'd1;
  assign acc_shift = {state.acc[CpW-7:0], byte_value[5:0]};

  always_comb begin
    state_next       = state;
    held_class_next  = held_class;
    result.emit      = 1'b0;
    result.code_point = '0;
    result.invalid   = 1'b0;
    result.text_done = end_of_text;

    if (state.owed != OWED_NONE) begin
      if (is_cont) begin
        state_next.acc  = acc_shift;
        state_next.owed = owed_dec;
        if (owed_dec == OWED_NONE) begin
          result.emit       = 1'b1;
          result.code_point = acc_shift;
        end
      end else begin
        // broken sequence; this byte is dropped
        result.emit    = 1'b1;
        result.invalid = 1'b1;
      end
    end else begin
      held_class_next = char_class;
      if (byte_value <= ASCII_MAX) begin
        result.emit       = 1'b1;
        result.code_point = CpW'(byte_value);
      end else if (byte_value <= CONT_MAX) begin
        result.emit    = 1'b1;
        result.invalid = 1'b1;
      end else if (byte_value <= LEAD2_MAX) begin
        state_next.acc  = CpW'(byte_value[4:0]);
        state_next.owed = OWED_ONE;
      end else if (byte_value <= LEAD3_MAX) begin
        state_next.acc  = CpW'(byte_value[3:0]);
        state_next.owed = OWED_TWO;
      end else if (byte_value <= LEAD4_MAX) begin
        state_next.acc  = CpW'(byte_value[2:0]);
        state_next.owed = OWED_THR;
      end else begin
        result.emit    = 1'b1;
        result.invalid = 1'b1;
      end
    end

    // text ended with bytes still owed: flush as invalid
    if (!result.emit && end_of_text) begin
      result.emit    = 1'b1;
      result.invalid = 1'b1;
    end

    if (result.emit) begin
      state_next.owed = OWED_NONE;
      state_next.acc  = '0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder; needs u8sd_pkg, u8sd_step and the macros header.
// Each byte taken is held in the input register; its result (if any) then loads the output register once it is free.
// Throughput: one word per cycle; s_axis_tready drops only while the input register
//   is full and the output register is held by m_axis_tready low.
// Reset (rst, synchronous): empties both registers and clears the sequence
//   state (owed count, accumulator, held class tag).
`default_nettype none
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder import u8sd_pkg::*; #(
  parameter int CLASS_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic [7:0]  s_axis_tuser,   // [7:0] char_class
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
  output logic [8:0]  m_axis_tuser,   // [0] invalid, [8:1] class_out
  output logic        m_axis_tlast    // text_done
);

  // Only the low CLASS_BITS (at most eight) of the tag are kept; the port carries eight.
  localparam int HeldW = (CLASS_BITS < 8) ? CLASS_BITS : 8;

  // Input register
  logic             in_valid;
  logic [7:0]       in_byte;
  logic [HeldW-1:0] in_class;
  logic             in_eot;

  // Sequence state
  dec_state_t       state;
  logic [HeldW-1:0] held_class;

  // Step outputs
  dec_state_t       state_next;
  logic [HeldW-1:0] held_class_next;
  dec_result_t      result;

  // Output register
  logic             out_valid;
  logic [CpW-1:0]   out_cp;
  logic             out_invalid;
  logic [HeldW-1:0] out_class;
  logic             out_done;

  logic out_free;
  logic advance;

  // The output register can take a result when empty or being drained.
  assign out_free      = !out_valid || m_axis_tready;
  // Word in the input register is decoded this cycle.
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || advance;

  u8sd_step #(
    .HELD_W (HeldW)
  ) u_step (
    .byte_value      (in_byte),
    .char_class      (in_class),
    .end_of_text     (in_eot),
    .state           (state),
    .held_class      (held_class),
    .state_next      (state_next),
    .held_class_next (held_class_next),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      out_valid  <= 1'b0;
      state      <= '0;
      held_class <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
        in_byte  <= s_axis_tdata;
        in_class <= s_axis_tuser[HeldW-1:0];
        in_eot   <= s_axis_tlast;
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        state      <= state_next;
        held_class <= held_class_next;
      end

      // load a new result, or retire the one just taken
      if (advance && result.emit) begin
        out_valid   <= 1'b1;
        out_cp      <= result.code_point;
        out_invalid <= result.invalid;
        out_class   <= held_class_next;
        out_done    <= result.text_done;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_cp};
  assign m_axis_tuser  = {8'(out_class), out_invalid};
  assign m_axis_tlast  = out_done;

  // Assertions
  `U8SD_ASSERT_SAME(a_idle_acc_clear, clk, rst, state.owed == OWED_NONE, state.acc == '0, "accumulator not cleared while idle")
  `U8SD_ASSERT_SAME(a_invalid_zero, clk, rst, out_valid && out_invalid, out_cp == '0, "invalid result carries a code point")
  `U8SD_ASSERT_NEXT(a_emit_loads, clk, rst, advance && result.emit, out_valid, "emitted result not registered")
  `U8SD_ASSERT_SAME(a_empty_ready, clk, rst, !in_valid, s_axis_tready, "empty input stage not ready")

endmodule

`default_nettype wire
